/* hdl/bpl_pkg.sv */
// Shared types, codes and sizes for the bounded positional list.
package bpl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VAL_W    = 32;
    localparam int SPOS_W   = 8;
    localparam int REQ_W    = 3;
    localparam int OPOS_W   = 7;
    localparam int HELD_W   = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_READOUT   = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic             out_load;
        status_t          out_status;
        logic             out_elem;
        logic [CNT_W-1:0] out_pos;
        logic             out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             out_free;
    } dp_stat_t;

endpackage

/* hdl/bpl_ctrl.sv */
// Controller: request decoding, checks and the readout sequencer.
module bpl_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bpl_pkg::REQ_W-1:0]     req_type,
    input  logic [bpl_pkg::SPOS_W-1:0]    slot_position,
    input  bpl_pkg::dp_stat_t             stat,
    output bpl_pkg::dp_cmd_t              cmd
);

    bpl_pkg::state_t                  state_reg, state_next;
    logic [bpl_pkg::CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;

    logic                             accept;
    logic                             is_full;
    logic                             is_empty;
    logic                             ins_bad;
    logic                             del_bad;
    logic [bpl_pkg::SPOS_W:0]         pos_ext;
    logic [bpl_pkg::SPOS_W:0]         cnt_ext;
    logic [bpl_pkg::SPOS_W-1:0]       pos_m1;
    logic [bpl_pkg::CNT_W-1:0]        cnt_m1;
    logic [bpl_pkg::CNT_W-1:0]        rd_pos;
    logic                             rd_last;
    bpl_pkg::req_t                    req;

    // Decode and range checks.
    always_comb begin
        req      = bpl_pkg::req_t'(req_type);
        is_full  = (stat.count >= bpl_pkg::CNT_W'(bpl_pkg::CAPACITY));
        is_empty = (stat.count == '0);
        pos_ext  = {1'b0, slot_position};
        cnt_ext  = (bpl_pkg::SPOS_W + 1)'(stat.count);
        ins_bad  = (slot_position == '0) || (pos_ext > cnt_ext + 1'b1);
        del_bad  = (slot_position == '0) || (pos_ext > cnt_ext);
        pos_m1   = slot_position - 1'b1;
        cnt_m1   = stat.count - 1'b1;
        rd_pos   = rd_cnt_reg + 1'b1;
        rd_last  = (rd_pos == stat.count);
        s_tready = (state_reg == bpl_pkg::S_IDLE) && stat.out_free;
        accept   = s_tvalid && s_tready;
    end

    // Next state.
    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            bpl_pkg::S_IDLE: begin
                if (accept && (req == bpl_pkg::REQ_READOUT) && !is_empty) begin
                    state_next  = bpl_pkg::S_READ;
                    rd_cnt_next = '0;
                end
            end
            bpl_pkg::S_READ: begin
                if (stat.out_free) begin
                    rd_cnt_next = rd_pos;
                    if (rd_last) begin
                        state_next = bpl_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = bpl_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd            = '0;
        cmd.op         = bpl_pkg::OP_HOLD;
        cmd.out_status = bpl_pkg::ST_OK;
        cmd.out_last   = 1'b1;
        unique case (state_reg)
            bpl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (req)
                        bpl_pkg::REQ_INS_FRONT: begin
                            cmd.out_load = 1'b1;
                            if (is_full) begin
                                cmd.out_status = bpl_pkg::ST_FULL;
                            end else begin
                                cmd.op  = bpl_pkg::OP_INSERT;
                                cmd.idx = '0;
                            end
                        end
                        bpl_pkg::REQ_INS_BACK: begin
                            cmd.out_load = 1'b1;
                            if (is_full) begin
                                cmd.out_status = bpl_pkg::ST_FULL;
                            end else begin
                                cmd.op  = bpl_pkg::OP_INSERT;
                                cmd.idx = bpl_pkg::IDX_W'(stat.count);
                            end
                        end
                        bpl_pkg::REQ_INS_POS: begin
                            cmd.out_load = 1'b1;
                            if (ins_bad) begin
                                cmd.out_status = bpl_pkg::ST_RANGE;
                            end else if (is_full) begin
                                cmd.out_status = bpl_pkg::ST_FULL;
                            end else begin
                                cmd.op  = bpl_pkg::OP_INSERT;
                                cmd.idx = bpl_pkg::IDX_W'(pos_m1);
                            end
                        end
                        bpl_pkg::REQ_DEL_FRONT: begin
                            cmd.out_load = 1'b1;
                            if (is_empty) begin
                                cmd.out_status = bpl_pkg::ST_EMPTY;
                            end else begin
                                cmd.op  = bpl_pkg::OP_REMOVE;
                                cmd.idx = '0;
                            end
                        end
                        bpl_pkg::REQ_DEL_BACK: begin
                            cmd.out_load = 1'b1;
                            if (is_empty) begin
                                cmd.out_status = bpl_pkg::ST_EMPTY;
                            end else begin
                                cmd.op  = bpl_pkg::OP_REMOVE;
                                cmd.idx = bpl_pkg::IDX_W'(cnt_m1);
                            end
                        end
                        bpl_pkg::REQ_DEL_POS: begin
                            cmd.out_load = 1'b1;
                            if (is_empty) begin
                                cmd.out_status = bpl_pkg::ST_EMPTY;
                            end else if (del_bad) begin
                                cmd.out_status = bpl_pkg::ST_RANGE;
                            end else begin
                                cmd.op  = bpl_pkg::OP_REMOVE;
                                cmd.idx = bpl_pkg::IDX_W'(pos_m1);
                            end
                        end
                        bpl_pkg::REQ_READOUT: begin
                            if (is_empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = bpl_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b0;
                        end
                    endcase
                end
            end
            bpl_pkg::S_READ: begin
                if (stat.out_free) begin
                    cmd.op       = bpl_pkg::OP_ROTATE;
                    cmd.out_load = 1'b1;
                    cmd.out_elem = 1'b1;
                    cmd.out_pos  = rd_pos;
                    cmd.out_last = rd_last;
                end
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bpl_pkg::S_IDLE;
            rd_cnt_reg <= '0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpl_pkg::S_READ) |-> (stat.count != '0))
        else $error("readout running on an empty list");

    a_read_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpl_pkg::S_READ) |-> (rd_cnt_reg < stat.count))
        else $error("readout index past the end of the list");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while output register is occupied");

endmodule

/* hdl/bpl_dpath.sv */
// Datapath: the shifting row of list cells, the element count and the result register.
module bpl_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bpl_pkg::dp_cmd_t              cmd,
    output bpl_pkg::dp_stat_t             stat,
    input  logic [bpl_pkg::VAL_W-1:0]     item_value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bpl_pkg::VAL_W-1:0]     out_value,
    output logic [bpl_pkg::CNT_W-1:0]     out_position,
    output logic [bpl_pkg::CNT_W-1:0]     elements_held,
    output bpl_pkg::status_t              status,
    output logic                          last_of_run
);

    logic [bpl_pkg::VAL_W-1:0]  cells_reg [bpl_pkg::CAPACITY];
    logic [bpl_pkg::VAL_W-1:0]  cells_next [bpl_pkg::CAPACITY];
    logic [bpl_pkg::VAL_W-1:0]  up_val [bpl_pkg::CAPACITY];
    logic [bpl_pkg::VAL_W-1:0]  dn_val [bpl_pkg::CAPACITY];
    logic [bpl_pkg::CNT_W-1:0]  count_reg, count_next;

    logic                       m_tvalid_reg;
    logic [bpl_pkg::VAL_W-1:0]  value_reg;
    logic [bpl_pkg::CNT_W-1:0]  pos_reg;
    logic [bpl_pkg::CNT_W-1:0]  held_reg;
    bpl_pkg::status_t           status_reg;
    logic                       last_reg;

    // Neighbor taps; the ends of the row see themselves or the new value.
    for (genvar i = 0; i < bpl_pkg::CAPACITY; i++) begin : g_tap
        if (i == bpl_pkg::CAPACITY - 1) begin : g_top
            assign up_val[i] = cells_reg[i];
        end else begin : g_mid
            assign up_val[i] = cells_reg[i+1];
        end
        if (i == 0) begin : g_bot
            assign dn_val[i] = item_value;
        end else begin : g_low
            assign dn_val[i] = cells_reg[i-1];
        end
    end

    // Every cell picks its next value in parallel.
    for (genvar i = 0; i < bpl_pkg::CAPACITY; i++) begin : g_cell
        always_comb begin
            cells_next[i] = cells_reg[i];
            case (cmd.op)
                bpl_pkg::OP_INSERT: begin
                    if (bpl_pkg::IDX_W'(i) == cmd.idx) begin
                        cells_next[i] = item_value;
                    end else if (bpl_pkg::IDX_W'(i) > cmd.idx) begin
                        cells_next[i] = dn_val[i];
                    end
                end
                bpl_pkg::OP_REMOVE: begin
                    if (bpl_pkg::IDX_W'(i) >= cmd.idx) begin
                        cells_next[i] = up_val[i];
                    end
                end
                bpl_pkg::OP_ROTATE: begin
                    if (bpl_pkg::CNT_W'(i + 1) == count_reg) begin
                        cells_next[i] = cells_reg[0];
                    end else if (bpl_pkg::CNT_W'(i + 1) < count_reg) begin
                        cells_next[i] = up_val[i];
                    end
                end
                default: begin
                    cells_next[i] = cells_reg[i];
                end
            endcase
        end
    end

    always_comb begin
        case (cmd.op)
            bpl_pkg::OP_INSERT: count_next = count_reg + 1'b1;
            bpl_pkg::OP_REMOVE: count_next = count_reg - 1'b1;
            default:            count_next = count_reg;
        endcase
        stat.count    = count_reg;
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < bpl_pkg::CAPACITY; i++) begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_reg  <= cmd.out_elem ? cells_reg[0] : '0;
            pos_reg    <= cmd.out_elem ? cmd.out_pos : '0;
            held_reg   <= count_next;
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign out_value     = value_reg;
    assign out_position  = pos_reg;
    assign elements_held = held_reg;
    assign status        = status_reg;
    assign last_of_run   = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bpl_pkg::CNT_W'(bpl_pkg::CAPACITY))
        else $error("element count above capacity");

    a_rotate_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bpl_pkg::OP_ROTATE) |=> (count_reg == $past(count_reg)))
        else $error("readout rotation changed the element count");

    a_edit_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == bpl_pkg::OP_INSERT || cmd.op == bpl_pkg::OP_REMOVE)
            |-> cmd.out_load)
        else $error("list edit without a status result");

endmodule

/* hdl/bounded_positional_list_top.sv */
// Top level of the bounded positional list: stream ports, controller and datapath.
// An edit request is checked and applied, and its status result loaded into the output
// register, in the cycle it is accepted. A new request is taken every cycle while no readout
// runs and that register is empty or being drained. A readout starts, then gives one element
// per cycle while that register is free, as the cells rotate past the front cell.
// Reset (aresetn low at a clock edge) empties the list and the output; cells are not cleared.
module bounded_positional_list_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] item_value, [39:32] slot_position
    input  logic [bpl_pkg::S_DATA_W-1:0]     s_tdata,
    // [2:0] req_type
    input  logic [bpl_pkg::REQ_W-1:0]        s_tuser,
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] out_value, [38:32] out_position, [45:39] elements_held, [47:46] zero
    output logic [bpl_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [1:0]                       m_tuser,
    // Marks the final result of a request.
    output logic                             m_tlast
);

    // The controller and datapath talk only through these two bundles.
    bpl_pkg::dp_cmd_t                cmd;
    bpl_pkg::dp_stat_t               stat;

    logic [bpl_pkg::VAL_W-1:0]       out_value;
    logic [bpl_pkg::CNT_W-1:0]       out_position;
    logic [bpl_pkg::CNT_W-1:0]       elements_held;
    bpl_pkg::status_t                status;

    // The controller decodes each request, applies the empty, range and full checks
    // in the order the list defines, and sequences the readout one element at a time.
    bpl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser),
        .slot_position (s_tdata[bpl_pkg::VAL_W +: bpl_pkg::SPOS_W]),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds the cells, which shift in parallel on an insert, a delete or a readout
    // rotation, the element count, and the registered result.
    bpl_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .item_value    (s_tdata[bpl_pkg::VAL_W-1:0]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_value     (out_value),
        .out_position  (out_position),
        .elements_held (elements_held),
        .status        (status),
        .last_of_run   (m_tlast)
    );

    // Pack the result fields, lowest first, padded with zeros to whole bytes.
    assign m_tdata = {2'b00,
                      bpl_pkg::HELD_W'(elements_held),
                      bpl_pkg::OPOS_W'(out_position),
                      out_value};
    assign m_tuser = status;

endmodule
